// ===== src/pbe_pkg.sv =====
`timescale 1ns / 1ps

package pbe_pkg;

    localparam int BAR_IDX_W   = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic CMD_HIT = 1'b0;
    localparam logic CMD_EOE = 1'b1;

    localparam logic [1:0] CFG_WINDOW_LOW    = 2'd0;
    localparam logic [1:0] CFG_WINDOW_HIGH   = 2'd1;
    localparam logic [1:0] CFG_FULL_FIRE_MIN = 2'd2;

    localparam logic [14:0] WINDOW_LOW_RST  = 15'd0;
    localparam logic [14:0] WINDOW_HIGH_RST = 15'd32000;
    localparam logic [4:0]  FULL_FIRE_RST   = 5'd16;

    localparam logic [3:0] MULT_MAX  = 4'd15;
    localparam logic [4:0] FIRED_MAX = 5'd31;

    typedef struct packed {
        logic [14:0] window_low;
        logic [14:0] window_high;
        logic [4:0]  full_fire_min;
    } t_cfg;

    typedef struct packed {
        logic                 kind;
        logic                 side;
        logic [BAR_IDX_W-1:0] bar;
        logic [15:0]          integral;
        logic [11:0]          amplitude;
        logic [14:0]          ptime;
    } t_cmd;

    typedef struct packed {
        logic [15:0] integral;
        logic [11:0] amplitude;
        logic [14:0] ptime;
        logic [3:0]  mult;
    } t_side;

    typedef struct packed {
        logic [2:0]  bar_index;
        logic [15:0] time_difference;
        logic        pair_valid;
        logic [15:0] bottom_integral_max;
        logic [15:0] top_integral_max;
        logic [11:0] bottom_amplitude_at_max;
        logic [11:0] top_amplitude_at_max;
        logic [3:0]  top_hit_count;
        logic [3:0]  bottom_hit_count;
        logic [4:0]  fired_sides;
        logic        full_event;
        logic        last_bar;
    } t_result;

endpackage

// ===== src/paddle_hit_event_builder.sv =====
`timescale 1ns / 1ps

// Event builder for a two-ended paddle array. Every cycle one item can enter: a pulse hit
// (tuser 0) updates the per-side hit count and the kept max-integral pulse of its bar in a
// single read-modify-write, and hits outside the time window or the array are dropped at the
// input. An end-of-event item (tuser 1) makes the block stream BAR_COUNT results, one per
// cycle while the output is taken, bar 0 first, tlast on the final bar, clearing each bar as
// its result leaves. Items arriving meanwhile wait in a 4-entry queue; input tready falls only
// when that queue is full, so an end-of-event item holds the back end, which pops nothing,
// until the result of the final bar has been loaded into the output register. Configuration
// index 0 is window_low, 1 window_high, 2 full_fire_min; write it only while no event
// readout is pending.
module paddle_hit_event_builder import pbe_pkg::*; #(
    parameter int BAR_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // side[0], paddle_number[4:1], pulse_integral[20:5], pulse_amplitude[32:21],
    // hit_time[47:33]
    input  logic [47:0] i_s_tdata,
    // action[0]
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // bar_index[2:0], time_difference[18:3], pair_valid[19], bottom_integral_max[35:20],
    // top_integral_max[51:36], bottom_amplitude_at_max[63:52], top_amplitude_at_max[75:64],
    // top_hit_count[79:76], bottom_hit_count[83:80], fired_sides[88:84], full_event[89],
    // zero fill[95:90]
    output logic [95:0] o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    w_push;
    t_cmd    w_cmd;
    logic    w_full;
    logic    w_pop;
    logic    w_empty;
    t_cmd    w_head;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_low    <= WINDOW_LOW_RST;
            r_cfg.window_high   <= WINDOW_HIGH_RST;
            r_cfg.full_fire_min <= FULL_FIRE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_LOW:    r_cfg.window_low    <= i_cfg_wdata;
                CFG_WINDOW_HIGH:   r_cfg.window_high   <= i_cfg_wdata;
                CFG_FULL_FIRE_MIN: r_cfg.full_fire_min <= i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    pbe_front #(
        .BAR_COUNT(BAR_COUNT)
    ) u_front (
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser),
        .i_side      (i_s_tdata[0]),
        .i_paddle    (i_s_tdata[4:1]),
        .i_integral  (i_s_tdata[20:5]),
        .i_amplitude (i_s_tdata[32:21]),
        .i_ptime     (i_s_tdata[47:33]),
        .i_cfg       (r_cfg),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    pbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    pbe_back #(
        .BAR_COUNT(BAR_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_full_fire_min (r_cfg.full_fire_min),
        .i_m_ready       (i_m_tready),
        .o_valid         (o_m_tvalid),
        .o_result        (w_res)
    );

    assign o_m_tdata = {6'b000000,
                        w_res.full_event,
                        w_res.fired_sides,
                        w_res.bottom_hit_count,
                        w_res.top_hit_count,
                        w_res.top_amplitude_at_max,
                        w_res.bottom_amplitude_at_max,
                        w_res.top_integral_max,
                        w_res.bottom_integral_max,
                        w_res.pair_valid,
                        w_res.time_difference,
                        w_res.bar_index};
    assign o_m_tlast = w_res.last_bar;

endmodule

// ===== src/pbe_front.sv =====
`timescale 1ns / 1ps

module pbe_front import pbe_pkg::*; #(
    parameter int BAR_COUNT = 8
) (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic        i_side,
    input  logic [3:0]  i_paddle,
    input  logic [15:0] i_integral,
    input  logic [11:0] i_amplitude,
    input  logic [14:0] i_ptime,
    input  t_cfg        i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic                 w_in_range;
    logic                 w_in_window;
    logic                 w_keep;
    logic [BAR_IDX_W-1:0] w_bar;

    assign w_in_range  = (i_paddle != 4'd0) && ({2'b00, i_paddle} <= 6'(BAR_COUNT));
    assign w_in_window = (i_ptime >= i_cfg.window_low) && (i_ptime <= i_cfg.window_high);
    // hits that fall outside the array or the window never reach the queue
    assign w_keep      = (i_action == CMD_EOE) || (w_in_range && w_in_window);
    assign w_bar       = {1'b0, i_paddle} - 5'd1;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && w_keep;

    always_comb begin
        o_cmd.kind      = i_action;
        o_cmd.side      = i_side;
        o_cmd.bar       = w_bar;
        o_cmd.integral  = i_integral;
        o_cmd.amplitude = i_amplitude;
        o_cmd.ptime     = i_ptime;
    end

endmodule

// ===== src/pbe_fifo.sv =====
`timescale 1ns / 1ps

module pbe_fifo import pbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty   = r_count == '0;
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/pbe_back.sv =====
`timescale 1ns / 1ps

module pbe_back import pbe_pkg::*; #(
    parameter int BAR_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    input  logic [4:0] i_full_fire_min,
    input  logic       i_m_ready,
    output logic       o_valid,
    output t_result    o_result
);

    localparam int IDX_W = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    logic [IDX_W-1:0] r_cnt;
    logic [4:0]       r_fired;
    t_side            r_bot [BAR_COUNT];
    t_side            r_top [BAR_COUNT];
    logic             r_out_valid;
    t_result          r_out;

    logic [IDX_W-1:0] w_rd_idx;
    t_side            w_bot;
    t_side            w_top;
    t_side            w_cur;
    t_side            w_upd;
    logic             w_out_ld;
    logic             w_emit_step;
    logic             w_cnt_last;
    logic             w_hit_do;
    logic             w_eoe;
    logic             w_fire_new;
    logic             w_pair;
    logic [15:0]      w_diff;
    logic [31:0]      w_cnt_ext;
    t_result          w_res;

    // one read port: the bar being emitted, or the bar of the queued hit
    assign w_rd_idx = (r_state == ST_EMIT) ? r_cnt : i_head.bar[IDX_W-1:0];
    assign w_bot    = r_bot[w_rd_idx];
    assign w_top    = r_top[w_rd_idx];

    assign w_out_ld    = !r_out_valid || i_m_ready;
    assign w_emit_step = (r_state == ST_EMIT) && w_out_ld;
    assign w_cnt_last  = r_cnt == IDX_W'(BAR_COUNT - 1);

    assign o_pop    = (r_state == ST_RUN) && !i_empty;
    assign w_hit_do = o_pop && (i_head.kind == CMD_HIT);
    assign w_eoe    = o_pop && (i_head.kind == CMD_EOE);

    assign w_cur      = i_head.side ? w_top : w_bot;
    assign w_fire_new = (w_cur.mult == 4'd0) && (r_fired != FIRED_MAX);

    always_comb begin
        w_upd      = w_cur;
        w_upd.mult = (w_cur.mult == MULT_MAX) ? MULT_MAX : w_cur.mult + 4'd1;
        // strictly larger only, so a zero integral never replaces the kept pulse
        if (i_head.integral > w_cur.integral) begin
            w_upd.integral  = i_head.integral;
            w_upd.amplitude = i_head.amplitude;
            w_upd.ptime     = i_head.ptime;
        end
    end

    assign w_pair    = (w_top.integral != 16'd0) && (w_bot.integral != 16'd0);
    assign w_diff    = {1'b0, w_top.ptime} - {1'b0, w_bot.ptime};
    assign w_cnt_ext = 32'(r_cnt);

    always_comb begin
        w_res.bar_index               = w_cnt_ext[2:0];
        w_res.time_difference         = w_pair ? w_diff : 16'd0;
        w_res.pair_valid              = w_pair;
        w_res.bottom_integral_max     = w_bot.integral;
        w_res.top_integral_max        = w_top.integral;
        w_res.bottom_amplitude_at_max = w_bot.amplitude;
        w_res.top_amplitude_at_max    = w_top.amplitude;
        w_res.top_hit_count           = w_top.mult;
        w_res.bottom_hit_count        = w_bot.mult;
        w_res.fired_sides             = r_fired;
        w_res.full_event              = r_fired >= i_full_fire_min;
        w_res.last_bar                = w_cnt_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_fired     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BAR_COUNT; i++) begin
                r_bot[i] <= '0;
                r_top[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    if (w_eoe) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_emit_step) begin
                        if (w_cnt_last) begin
                            r_state <= ST_RUN;
                            r_cnt   <= '0;
                            r_fired <= '0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase

            if (w_hit_do) begin
                if (i_head.side) begin
                    r_top[w_rd_idx] <= w_upd;
                end else begin
                    r_bot[w_rd_idx] <= w_upd;
                end
                if (w_fire_new) begin
                    r_fired <= r_fired + 5'd1;
                end
            end

            // each bar is cleared as its result leaves
            if (w_emit_step) begin
                r_bot[w_rd_idx] <= '0;
                r_top[w_rd_idx] <= '0;
            end

            if (w_out_ld) begin
                r_out_valid <= w_emit_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_step) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_no_pop_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !o_pop)
        else $error("queue popped while results are being emitted");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_step && w_cnt_last) |=> (r_state == ST_RUN && r_fired == 5'd0))
        else $error("event state not cleared after the last bar");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cnt == '0))
        else $error("bar counter not at zero between events");

    a_step_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_step |=> (r_out_valid && r_out.last_bar == $past(w_cnt_last)))
        else $error("emitted bar did not reach the output register");

endmodule
